@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the SM3 engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, quiet while reset is high.
`define SM3_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked property that also holds during reset.
`define SM3_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hw/rtl/sm3_pkg.sv @@
// Package with types, constants and helpers of the SM3 hash engine.
package sm3_pkg;

   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);

   localparam logic [31:0] T_LOW  = 32'h79CC4519;
   localparam logic [31:0] T_HIGH = 32'h7A879D8A;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   localparam logic [31:0] STD_IV [8] = '{
      32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
      32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
   };

   // Configuration register indexes
   localparam logic [2:0] CSR_USE_LOADED_IV = 3'd0;
   localparam logic [2:0] CSR_IV_WORDS_0_1  = 3'd1;
   localparam logic [2:0] CSR_IV_WORDS_2_3  = 3'd2;
   localparam logic [2:0] CSR_IV_WORDS_4_5  = 3'd3;
   localparam logic [2:0] CSR_IV_WORDS_6_7  = 3'd4;
   localparam logic [2:0] CSR_PRIOR_BLOCKS  = 3'd5;

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic        end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef struct packed {
      logic             use_loaded_iv;
      logic [3:0][63:0] iv_words;
      logic [54:0]      prior_blocks;
   } cfg_type;

   // Work passed from front to back
   typedef enum logic [1:0] {
      Q_WORD   = 2'd0,
      Q_LOAD   = 2'd1,
      Q_FINISH = 2'd2
   } q_kind_type;

   typedef struct packed {
      q_kind_type  kind;
      logic [31:0] word;
   } q_entry_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ rotl(x, 9) ^ rotl(x, 17);
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      return x ^ rotl(x, 15) ^ rotl(x, 23);
   endfunction

endpackage

@@ hw/rtl/sm3_queue.sv @@
// Short queue of work entries between the front and back parts.
module sm3_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sm3_pkg::q_entry_type push_data,
   output logic               full,
   input  logic               pop,
   output sm3_pkg::q_entry_type pop_data,
   output logic               empty
);
   import sm3_pkg::*;

   q_entry_type            mem [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrW:0]     count_ff, count_in;
   logic                   do_push, do_pop;

   assign full     = (count_ff == (QueuePtrW+1)'(QueueDepth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/sm3_front.sv @@
// Front part: takes message items, packs bytes into words, adds padding and length.
module sm3_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sm3_pkg::req_type     req_data,
   input  logic [54:0]          prior_blocks,
   output logic                 q_push,
   output sm3_pkg::q_entry_type q_data,
   input  logic                 q_full
);
   import sm3_pkg::*;

   typedef enum logic [7:0] {
      F_IDLE   = 8'b0000_0001,
      F_LOAD   = 8'b0000_0010,
      F_MERGE  = 8'b0000_0100,
      F_PAD    = 8'b0000_1000,
      F_ZERO   = 8'b0001_0000,
      F_LEN_HI = 8'b0010_0000,
      F_LEN_LO = 8'b0100_0000,
      F_FIN    = 8'b1000_0000
   } f_state_type;

   f_state_type state_ff, state_in;
   logic [31:0] data_ff, data_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        eom_ff, eom_in;
   logic [23:0] part_ff, part_in;
   logic [1:0]  pbytes_ff, pbytes_in;
   logic [3:0]  wcnt_ff, wcnt_in;
   logic [60:0] mbytes_ff, mbytes_in;
   logic [31:0] len_lo_ff, len_lo_in;

   logic        accept;
   logic [2:0]  csat;
   logic [31:0] dmask;
   logic [55:0] acc;
   logic [3:0]  total;
   logic [31:0] pad_word;
   logic [63:0] bit_len;

   assign req_stall = (state_ff != F_IDLE);
   assign accept    = req_valid && !req_stall;

   // Byte count saturates at four; unused bytes are cleared
   always_comb begin
      csat = (req_data.byte_count > 3'd4) ? 3'd4 : req_data.byte_count;
      unique case (csat)
         3'd0:    dmask = 32'h0000_0000;
         3'd1:    dmask = 32'hFF00_0000;
         3'd2:    dmask = 32'hFFFF_0000;
         3'd3:    dmask = 32'hFFFF_FF00;
         default: dmask = 32'hFFFF_FFFF;
      endcase
   end

   // Merge new bytes behind the pending partial word
   assign acc      = {part_ff, 32'h0} | ({data_ff, 24'h0} >> {pbytes_ff, 3'b000});
   assign total    = {2'b00, pbytes_ff} + {1'b0, cnt_ff};
   assign pad_word = {part_ff, 8'h00} | ({PAD_BYTE, 24'h0} >> {pbytes_ff, 3'b000});
   assign bit_len  = {prior_blocks, 9'h0} + {mbytes_ff, 3'b000};

   always_comb begin
      state_in  = state_ff;
      data_in   = data_ff;
      cnt_in    = cnt_ff;
      eom_in    = eom_ff;
      part_in   = part_ff;
      pbytes_in = pbytes_ff;
      wcnt_in   = wcnt_ff;
      mbytes_in = mbytes_ff;
      len_lo_in = len_lo_ff;
      q_push    = 1'b0;
      q_data    = '{kind: Q_WORD, word: 32'h0};
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               data_in   = req_data.data_word & dmask;
               cnt_in    = csat;
               eom_in    = req_data.end_of_message;
               mbytes_in = mbytes_ff + 61'(csat);
               state_in  = (mbytes_ff == '0) ? F_LOAD : F_MERGE;
            end
         end
         F_LOAD: begin
            q_push = 1'b1;
            q_data = '{kind: Q_LOAD, word: 32'h0};
            if (!q_full) begin
               state_in = F_MERGE;
            end
         end
         F_MERGE: begin
            if (total >= 4'd4) begin
               q_push = 1'b1;
               q_data = '{kind: Q_WORD, word: acc[55:24]};
            end
            if (total < 4'd4 || !q_full) begin
               if (total >= 4'd4) begin
                  part_in = acc[23:0];
                  wcnt_in = wcnt_ff + 1'b1;
               end else begin
                  part_in = acc[55:32];
               end
               pbytes_in = total[1:0];
               state_in  = eom_ff ? F_PAD : F_IDLE;
            end
         end
         F_PAD: begin
            q_push = 1'b1;
            q_data = '{kind: Q_WORD, word: pad_word};
            if (!q_full) begin
               part_in   = '0;
               pbytes_in = '0;
               wcnt_in   = wcnt_ff + 1'b1;
               state_in  = (wcnt_ff == 4'd13) ? F_LEN_HI : F_ZERO;
            end
         end
         F_ZERO: begin
            q_push = 1'b1;
            q_data = '{kind: Q_WORD, word: 32'h0};
            if (!q_full) begin
               wcnt_in  = wcnt_ff + 1'b1;
               state_in = (wcnt_ff == 4'd13) ? F_LEN_HI : F_ZERO;
            end
         end
         F_LEN_HI: begin
            q_push = 1'b1;
            q_data = '{kind: Q_WORD, word: bit_len[63:32]};
            if (!q_full) begin
               len_lo_in = bit_len[31:0];
               wcnt_in   = wcnt_ff + 1'b1;
               state_in  = F_LEN_LO;
            end
         end
         F_LEN_LO: begin
            q_push = 1'b1;
            q_data = '{kind: Q_WORD, word: len_lo_ff};
            if (!q_full) begin
               wcnt_in  = wcnt_ff + 1'b1;
               state_in = F_FIN;
            end
         end
         F_FIN: begin
            q_push = 1'b1;
            q_data = '{kind: Q_FINISH, word: 32'h0};
            if (!q_full) begin
               mbytes_in = '0;
               state_in  = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         part_ff   <= '0;
         pbytes_ff <= '0;
         wcnt_ff   <= '0;
         mbytes_ff <= '0;
      end else begin
         state_ff  <= state_in;
         part_ff   <= part_in;
         pbytes_ff <= pbytes_in;
         wcnt_ff   <= wcnt_in;
         mbytes_ff <= mbytes_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff   <= data_in;
      cnt_ff    <= cnt_in;
      eom_ff    <= eom_in;
      len_lo_ff <= len_lo_in;
   end

endmodule

@@ hw/rtl/sm3_back.sv @@
// Back part: block assembly, 64-round compression and digest output.
module sm3_back (
   input  logic                 clock,
   input  logic                 reset,
   input  sm3_pkg::cfg_type     cfg,
   output logic                 q_pop,
   input  sm3_pkg::q_entry_type q_data,
   input  logic                 q_empty,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sm3_pkg::rsp_type     rsp_data
);
   import sm3_pkg::*;
   `include "assert_macros.svh"

   typedef enum logic [3:0] {
      B_IDLE   = 4'b0001,
      B_ROUND  = 4'b0010,
      B_UPDATE = 4'b0100,
      B_OUT    = 4'b1000
   } b_state_type;

   b_state_type state_ff, state_in;
   logic [31:0] window_ff [16];
   logic [31:0] window_in [16];
   logic [31:0] cv_ff [8];
   logic [31:0] cv_in [8];
   logic [31:0] wr_ff [8];
   logic [31:0] wr_in [8];
   logic [5:0]  round_ff, round_in;
   logic [31:0] tj_ff, tj_in;
   logic [3:0]  widx_ff, widx_in;
   logic [2:0]  oidx_ff, oidx_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;

   logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, w_next;
   logic        out_load;

   // Round datapath
   always_comb begin
      a12 = rotl(wr_ff[0], 12);
      ss1 = rotl(a12 + wr_ff[4] + tj_ff, 7);
      ss2 = ss1 ^ a12;
      if (round_ff < 6'd16) begin
         ff = wr_ff[0] ^ wr_ff[1] ^ wr_ff[2];
         gg = wr_ff[4] ^ wr_ff[5] ^ wr_ff[6];
      end else begin
         ff = (wr_ff[0] & wr_ff[1]) | (wr_ff[0] & wr_ff[2]) | (wr_ff[1] & wr_ff[2]);
         gg = (wr_ff[4] & wr_ff[5]) | (~wr_ff[4] & wr_ff[6]);
      end
      tt1 = ff + wr_ff[3] + ss2 + (window_ff[0] ^ window_ff[4]);
      tt2 = gg + wr_ff[7] + ss1 + window_ff[0];
      w_next = perm1(window_ff[0] ^ window_ff[7] ^ rotl(window_ff[13], 15))
               ^ rotl(window_ff[3], 7) ^ window_ff[10];
   end

   assign q_pop    = (state_ff == B_IDLE) && !q_empty;
   assign out_load = (state_ff == B_OUT) && (!out_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      cv_in        = cv_ff;
      wr_in        = wr_ff;
      round_in     = round_ff;
      tj_in        = tj_ff;
      widx_in      = widx_ff;
      oidx_in      = oidx_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         B_IDLE: begin
            if (q_pop) begin
               unique case (q_data.kind)
                  Q_WORD: begin
                     for (int i = 0; i < 15; i++) begin
                        window_in[i] = window_ff[i+1];
                     end
                     window_in[15] = q_data.word;
                     widx_in = widx_ff + 1'b1;
                     if (widx_ff == 4'd15) begin
                        wr_in    = cv_ff;
                        round_in = '0;
                        tj_in    = T_LOW;
                        state_in = B_ROUND;
                     end
                  end
                  Q_LOAD: begin
                     for (int i = 0; i < 8; i++) begin
                        cv_in[i] = cfg.use_loaded_iv
                                   ? cfg.iv_words[i/2][(i%2 == 0) ? 63 : 31 -: 32]
                                   : STD_IV[i];
                     end
                  end
                  Q_FINISH: begin
                     oidx_in  = '0;
                     state_in = B_OUT;
                  end
                  default: state_in = B_IDLE;
               endcase
            end
         end
         B_ROUND: begin
            wr_in[3] = wr_ff[2];
            wr_in[2] = rotl(wr_ff[1], 9);
            wr_in[1] = wr_ff[0];
            wr_in[0] = tt1;
            wr_in[7] = wr_ff[6];
            wr_in[6] = rotl(wr_ff[5], 19);
            wr_in[5] = wr_ff[4];
            wr_in[4] = perm0(tt2);
            for (int i = 0; i < 15; i++) begin
               window_in[i] = window_ff[i+1];
            end
            window_in[15] = w_next;
            tj_in    = (round_ff == 6'd15) ? rotl(T_HIGH, 16) : rotl(tj_ff, 1);
            round_in = round_ff + 1'b1;
            if (round_ff == 6'd63) begin
               state_in = B_UPDATE;
            end
         end
         B_UPDATE: begin
            for (int i = 0; i < 8; i++) begin
               cv_in[i] = cv_ff[i] ^ wr_ff[i];
            end
            state_in = B_IDLE;
         end
         B_OUT: begin
            if (out_load) begin
               out_in       = '{digest_word: cv_ff[oidx_ff], word_index: oidx_ff,
                                last_word: (oidx_ff == 3'd7)};
               out_valid_in = 1'b1;
               oidx_in      = oidx_ff + 1'b1;
               if (oidx_ff == 3'd7) begin
                  state_in = B_IDLE;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         round_ff     <= '0;
         widx_ff      <= '0;
         oidx_ff      <= '0;
         out_valid_ff <= 1'b0;
         cv_ff        <= STD_IV;
         wr_ff        <= '{default: 32'h0};
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         widx_ff      <= widx_in;
         oidx_ff      <= oidx_in;
         out_valid_ff <= out_valid_in;
         cv_ff        <= cv_in;
         wr_ff        <= wr_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff <= window_in;
      tj_ff     <= tj_in;
      out_ff    <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `SM3_ASSERT(a_last_is_seven, rsp_valid && rsp_data.last_word |-> rsp_data.word_index == 3'd7, "last word without index 7")
   `SM3_ASSERT(a_round_exit, $fell(state_ff == B_ROUND) |-> $past(round_ff) == 6'd63, "compression left early")
   `SM3_ASSERT(a_pop_idle, q_pop |-> state_ff == B_IDLE && !q_empty, "queue read outside idle")

endmodule

@@ hw/rtl/sm3_hash_engine_top.sv @@
// Top level of the SM3 hash engine: configuration registers and part wiring.
//
// Message items enter on req_ (valid/stall): a big-endian data word, a byte
// count (values above four count as four) and an end-of-message flag. Every
// 16th word starts a compression of 64 rounds at one round per cycle, after
// which the result is folded into the chaining value. While the back
// computes, the queue fills and the front waits, so a long message of
// back-to-back words runs at a rate set by the single round unit. After the
// end item the front adds the 0x80 byte, zero fill and the 64-bit bit length
// (in the last block, or in one more block when it has no room), and the back
// returns the eight digest words on rsp_, word 0 first, last_word set on word 7.
// A four-entry queue separates front and back; when rsp_stall is high the
// output register holds its word and the back waits, the queue fills and then
// req_stall rises. csr_ writes take effect at once; the user must make them
// only while idle, which the block itself does not enforce.
// Synchronous reset loads the standard IV and clears all control state.
module sm3_hash_engine_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sm3_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sm3_pkg::rsp_type  rsp_data,
   input  logic              csr_write_enable,
   input  logic [2:0]        csr_index,
   input  logic [63:0]       csr_write_data
);
   import sm3_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   logic        q_push, q_full, q_pop, q_empty;
   q_entry_type q_wdata, q_rdata;

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_USE_LOADED_IV: cfg_in.use_loaded_iv = csr_write_data[0];
            CSR_IV_WORDS_0_1:  cfg_in.iv_words[0]   = csr_write_data;
            CSR_IV_WORDS_2_3:  cfg_in.iv_words[1]   = csr_write_data;
            CSR_IV_WORDS_4_5:  cfg_in.iv_words[2]   = csr_write_data;
            CSR_IV_WORDS_6_7:  cfg_in.iv_words[3]   = csr_write_data;
            CSR_PRIOR_BLOCKS:  cfg_in.prior_blocks  = csr_write_data[54:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sm3_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .prior_blocks (cfg_ff.prior_blocks),
      .q_push       (q_push),
      .q_data       (q_wdata),
      .q_full       (q_full)
   );

   sm3_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   sm3_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_pop     (q_pop),
      .q_data    (q_rdata),
      .q_empty   (q_empty),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
